[hw/rtl/qtcs_pkg.sv]
// Shared types, constants and register codes for the quad tile coverage scan.
// No dependencies.
package qtcs_pkg;

    localparam int NUM_VERTS     = 4;
    localparam int VIDX_W        = 2;
    localparam int SCAN_BUDGET   = 4096;
    localparam int BUDGET_W      = 13;
    localparam int SIZE_W        = 24;
    localparam int VERT_REG_W    = 64;
    localparam int HALF_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int DIG_W         = 16;
    localparam int S_TDATA_W     = 8;
    localparam int DEF_COORD_W   = 32;
    localparam int DEF_FRAC_BITS = 8;

    localparam logic [SIZE_W-1:0] TILE_RESET = 24'd256;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE = 3'd4;

    typedef logic [NUM_VERTS-1:0][VERT_REG_W-1:0] vert_bank_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_STEP,
        ST_EDGE,
        ST_MUL_A,
        ST_MUL_B,
        ST_OUT
    } scan_state_t;

endpackage

[hw/rtl/quad_tile_coverage_scan_core.sv]
// Quad tile coverage scan: top level with sequencer, grid walker and output register.
// Depends on qtcs_pkg, qtcs_cfg_regs and qtcs_mul_unit.
// Sequence: a restart first folds the four vertices into the bounding box; each grid position
// takes a bounds step, then per edge a direct test, or a multiplier pass when the crossing
// needs the two products (NDIG = ceil(COORD_WIDTH/16) digits, 2 at 32 bits), then delivery via ST_OUT.
// One item at a time, up to 4096 grid positions per item; the shared multiplier sets the pace.
// Reset (aresetn low, synchronous): no scan active, vertices 0, tile size 256; no clearing pass.
module quad_tile_coverage_scan_core
    import qtcs_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_W,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VERT_REG_W-1:0] cfg_data,
    // request items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] restart
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((2*(COORD_WIDTH+1)+7)/8)*8-1:0] m_tdata, // center_x, center_y
    output logic [0:0]            m_tuser,   // [0] found
    output logic                  m_tlast    // done_res
);

    localparam int CW      = COORD_WIDTH;
    localparam int IW      = ((CW > SIZE_W) ? CW : SIZE_W) + 3;
    localparam int OUT_W   = CW + 1;
    localparam int TDATA_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam int PW      = 2 * CW;
    localparam int CMP_W   = (PW > 64) ? 64 : PW;
    localparam logic [CW-1:0] FLOOR_MASK = ~CW'((64'd1 << FRAC_BITS) - 64'd1);

    vert_bank_t        vert_bank;
    logic [SIZE_W-1:0] tile_size;

    logic                  mul_start;
    logic [CW-1:0]         mul_a, mul_b;
    logic                  mul_done;
    logic [PW-1:0]         mul_prod;

    qtcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vert_bank (vert_bank),
        .tile_size (tile_size)
    );

    qtcs_mul_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // registers
    scan_state_t          state_reg, state_next;
    logic                 scan_active_reg, scan_active_next;
    logic signed [IW-1:0] scan_x_reg, scan_x_next;
    logic signed [IW-1:0] scan_y_reg, scan_y_next;
    logic signed [CW-1:0] box_min_y_reg, box_min_y_next;
    logic signed [CW-1:0] box_max_x_reg, box_max_x_next;
    logic signed [CW-1:0] box_max_y_reg, box_max_y_next;
    logic signed [CW-1:0] run_min_x_reg, run_min_x_next;
    logic signed [CW-1:0] run_min_y_reg, run_min_y_next;
    logic signed [CW-1:0] run_max_x_reg, run_max_x_next;
    logic signed [CW-1:0] run_max_y_reg, run_max_y_next;
    logic [VIDX_W-1:0]    vidx_reg, vidx_next;
    logic [VIDX_W-1:0]    edge_reg, edge_next;
    logic [BUDGET_W-1:0]  budget_reg, budget_next;
    logic signed [IW-1:0] cx_reg, cx_next;
    logic signed [IW-1:0] cy_reg, cy_next;
    logic                 inside_reg, inside_next;
    logic [CW-1:0]        t_reg, t_next;
    logic [CW-1:0]        dx_reg, dx_next;
    logic                 pos_reg, pos_next;
    logic [CMP_W-1:0]     prod_a_reg, prod_a_next;
    logic                 res_found_reg, res_found_next;
    logic                 res_done_reg, res_done_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_cx_reg, m_cx_next;
    logic [OUT_W-1:0]     m_cy_reg, m_cy_next;
    logic                 m_found_reg, m_found_next;
    logic                 m_done_reg, m_done_next;

    // vertex coordinates
    logic [VERT_REG_W-1:0] x_word [NUM_VERTS];
    logic signed [CW-1:0]  vx [NUM_VERTS];
    logic signed [CW-1:0]  vy [NUM_VERTS];
    logic signed [CW-1:0]  ea_x [NUM_VERTS];
    logic signed [CW-1:0]  ea_y [NUM_VERTS];
    logic signed [CW-1:0]  eb_x [NUM_VERTS];
    logic signed [CW-1:0]  eb_y [NUM_VERTS];

    always_comb begin
        for (int k = 0; k < NUM_VERTS; k++) begin
            x_word[k] = vert_bank[k] >> HALF_W;
            vx[k]     = x_word[k][CW-1:0];
            vy[k]     = vert_bank[k][CW-1:0];
        end
        for (int e = 0; e < NUM_VERTS; e++) begin
            ea_x[e] = vx[e];
            ea_y[e] = vy[e];
            eb_x[e] = vx[(e + 1) % NUM_VERTS];
            eb_y[e] = vy[(e + 1) % NUM_VERTS];
        end
    end

    // handshakes
    logic accept, restart, out_free;
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tdata[0];
    assign out_free = !m_tvalid_reg || m_tready;

    // bounding box step
    logic signed [CW-1:0] box_vx, box_vy;
    logic signed [CW-1:0] mnx_n, mny_n, mxx_n, mxy_n;
    logic signed [CW-1:0] mnx_fl, mny_fl;
    logic                 box_last;

    assign box_vx   = vx[vidx_reg];
    assign box_vy   = vy[vidx_reg];
    assign mnx_n    = (box_vx < run_min_x_reg) ? box_vx : run_min_x_reg;
    assign mny_n    = (box_vy < run_min_y_reg) ? box_vy : run_min_y_reg;
    assign mxx_n    = (box_vx > run_max_x_reg) ? box_vx : run_max_x_reg;
    assign mxy_n    = (box_vy > run_max_y_reg) ? box_vy : run_max_y_reg;
    assign mnx_fl   = mnx_n & FLOOR_MASK;
    assign mny_fl   = mny_n & FLOOR_MASK;
    assign box_last = (vidx_reg == VIDX_W'(NUM_VERTS - 1));

    // grid step
    logic [SIZE_W-1:0]    step_size;
    logic signed [IW-1:0] size_e, half_e, lim_x, lim_y;
    logic                 budget_out, x_over, y_over;

    assign step_size  = (tile_size == '0) ? SIZE_W'(1) : tile_size;
    assign size_e     = $signed(IW'(step_size));
    assign half_e     = $signed(IW'(step_size >> 1));
    assign lim_x      = IW'(box_max_x_reg) + size_e;
    assign lim_y      = IW'(box_max_y_reg) + size_e;
    assign budget_out = (budget_reg == BUDGET_W'(SCAN_BUDGET));
    assign x_over     = scan_x_reg > lim_x;
    assign y_over     = scan_y_reg > lim_y;

    // edge crossing test
    logic signed [IW-1:0] xa0, ya0, xb0, yb0, xa, ya, xb, yb;
    logic signed [IW-1:0] d_y, d_t, d_xp, d_xn, d_up, d_un;
    logic                 swap, in_band, left_both, right_both, pos_dir;
    logic [CW-1:0]        dy_u, t_u, dx_u, u_u;

    assign xa0        = IW'(ea_x[edge_reg]);
    assign ya0        = IW'(ea_y[edge_reg]);
    assign xb0        = IW'(eb_x[edge_reg]);
    assign yb0        = IW'(eb_y[edge_reg]);
    assign swap       = ya0 > yb0;
    assign xa         = swap ? xb0 : xa0;
    assign ya         = swap ? yb0 : ya0;
    assign xb         = swap ? xa0 : xb0;
    assign yb         = swap ? ya0 : yb0;
    assign in_band    = (ya <= cy_reg) && (cy_reg < yb);
    assign left_both  = (cx_reg < xa) && (cx_reg < xb);
    assign right_both = (cx_reg > xa) && (cx_reg > xb);
    assign pos_dir    = xb >= xa;
    assign d_y        = yb - ya;
    assign d_t        = cy_reg - ya;
    assign d_xp       = xb - xa;
    assign d_xn       = xa - xb;
    assign d_up       = cx_reg - xa;
    assign d_un       = xa - cx_reg;
    assign dy_u       = d_y[CW-1:0];
    assign t_u        = d_t[CW-1:0];
    assign dx_u       = pos_dir ? d_xp[CW-1:0] : d_xn[CW-1:0];
    assign u_u        = pos_dir ? d_up[CW-1:0] : d_un[CW-1:0];

    logic [CMP_W-1:0] prod_b;
    logic             edge_fin, edge_cross, edge_last, inside_n;

    assign prod_b    = mul_prod[CMP_W-1:0];
    assign edge_last = (edge_reg == VIDX_W'(NUM_VERTS - 1));
    assign inside_n  = inside_reg ^ edge_cross;

    always_comb begin
        edge_fin   = 1'b0;
        edge_cross = 1'b0;
        if (state_reg == ST_EDGE) begin
            edge_fin   = !in_band || left_both || right_both;
            edge_cross = in_band && left_both;
        end else if (state_reg == ST_MUL_B && mul_done) begin
            edge_fin   = 1'b1;
            edge_cross = pos_reg ? (prod_a_reg < prod_b) : (prod_a_reg > prod_b);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (restart)
                        state_next = ST_BOX;
                    else if (!scan_active_reg)
                        state_next = ST_OUT;
                    else
                        state_next = ST_STEP;
                end
            end
            ST_BOX: begin
                if (box_last)
                    state_next = ST_STEP;
            end
            ST_STEP: begin
                if (budget_out || x_over)
                    state_next = ST_OUT;
                else if (!y_over)
                    state_next = ST_EDGE;
            end
            ST_EDGE, ST_MUL_B: begin
                if (edge_fin) begin
                    if (!edge_last)
                        state_next = ST_EDGE;
                    else if (inside_n)
                        state_next = ST_OUT;
                    else
                        state_next = ST_STEP;
                end else if (state_reg == ST_EDGE) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                if (mul_done)
                    state_next = ST_MUL_B;
            end
            ST_OUT: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = t_reg;
        mul_b     = dx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EDGE: begin
                mul_start = !edge_fin;
                mul_a     = u_u;
                mul_b     = dy_u;
            end
            ST_MUL_A: begin
                mul_start = mul_done;
            end
            ST_BOX, ST_STEP, ST_MUL_B, ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        scan_active_next = scan_active_reg;
        scan_x_next      = scan_x_reg;
        scan_y_next      = scan_y_reg;
        box_min_y_next   = box_min_y_reg;
        box_max_x_next   = box_max_x_reg;
        box_max_y_next   = box_max_y_reg;
        run_min_x_next   = run_min_x_reg;
        run_min_y_next   = run_min_y_reg;
        run_max_x_next   = run_max_x_reg;
        run_max_y_next   = run_max_y_reg;
        vidx_next        = vidx_reg;
        edge_next        = edge_reg;
        budget_next      = budget_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        inside_next      = inside_reg;
        t_next           = t_reg;
        dx_next          = dx_reg;
        pos_next         = pos_reg;
        prod_a_next      = prod_a_reg;
        res_found_next   = res_found_reg;
        res_done_next    = res_done_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_cx_next        = m_cx_reg;
        m_cy_next        = m_cy_reg;
        m_found_next     = m_found_reg;
        m_done_next      = m_done_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    budget_next = '0;
                    if (restart) begin
                        run_min_x_next = vx[0];
                        run_min_y_next = vy[0];
                        run_max_x_next = vx[0];
                        run_max_y_next = vy[0];
                        vidx_next      = VIDX_W'(1);
                    end else if (!scan_active_reg) begin
                        res_found_next = 1'b0;
                        res_done_next  = 1'b1;
                    end
                end
            end
            ST_BOX: begin
                run_min_x_next = mnx_n;
                run_min_y_next = mny_n;
                run_max_x_next = mxx_n;
                run_max_y_next = mxy_n;
                vidx_next      = vidx_reg + VIDX_W'(1);
                if (box_last) begin
                    box_min_y_next   = mny_fl;
                    box_max_x_next   = mxx_n;
                    box_max_y_next   = mxy_n;
                    scan_x_next      = IW'(mnx_fl);
                    scan_y_next      = IW'(mny_fl);
                    scan_active_next = 1'b1;
                end
            end
            ST_STEP: begin
                if (budget_out) begin
                    res_found_next = 1'b0;
                    res_done_next  = 1'b0;
                end else begin
                    budget_next = budget_reg + BUDGET_W'(1);
                    if (x_over) begin
                        scan_active_next = 1'b0;
                        res_found_next   = 1'b0;
                        res_done_next    = 1'b1;
                    end else if (y_over) begin
                        scan_x_next = scan_x_reg + size_e;
                        scan_y_next = IW'(box_min_y_reg);
                    end else begin
                        cx_next     = scan_x_reg + half_e;
                        cy_next     = scan_y_reg + half_e;
                        scan_y_next = scan_y_reg + size_e;
                        inside_next = 1'b0;
                        edge_next   = '0;
                    end
                end
            end
            ST_EDGE, ST_MUL_B: begin
                if (edge_fin) begin
                    inside_next = inside_n;
                    edge_next   = edge_reg + VIDX_W'(1);
                    if (edge_last && inside_n) begin
                        res_found_next = 1'b1;
                        res_done_next  = 1'b0;
                    end
                end else if (state_reg == ST_EDGE) begin
                    t_next   = t_u;
                    dx_next  = dx_u;
                    pos_next = pos_dir;
                end
            end
            ST_MUL_A: begin
                if (mul_done)
                    prod_a_next = mul_prod[CMP_W-1:0];
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_cx_next     = res_found_reg ? cx_reg[OUT_W-1:0] : '0;
                    m_cy_next     = res_found_reg ? cy_reg[OUT_W-1:0] : '0;
                    m_found_next  = res_found_reg;
                    m_done_next   = res_done_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            scan_active_reg <= 1'b0;
            scan_x_reg      <= '0;
            scan_y_reg      <= '0;
            box_min_y_reg   <= '0;
            box_max_x_reg   <= '0;
            box_max_y_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            scan_active_reg <= scan_active_next;
            scan_x_reg      <= scan_x_next;
            scan_y_reg      <= scan_y_next;
            box_min_y_reg   <= box_min_y_next;
            box_max_x_reg   <= box_max_x_next;
            box_max_y_reg   <= box_max_y_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_min_x_reg <= run_min_x_next;
        run_min_y_reg <= run_min_y_next;
        run_max_x_reg <= run_max_x_next;
        run_max_y_reg <= run_max_y_next;
        vidx_reg      <= vidx_next;
        edge_reg      <= edge_next;
        budget_reg    <= budget_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        inside_reg    <= inside_next;
        t_reg         <= t_next;
        dx_reg        <= dx_next;
        pos_reg       <= pos_next;
        prod_a_reg    <= prod_a_next;
        res_found_reg <= res_found_next;
        res_done_reg  <= res_done_next;
        m_cx_reg      <= m_cx_next;
        m_cy_reg      <= m_cy_next;
        m_found_reg   <= m_found_next;
        m_done_reg    <= m_done_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({m_cy_reg, m_cx_reg});
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_done_reg;

    a_found_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_found_reg && m_done_reg))
        else $error("result marked both covered and exhausted");

    a_budget_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (budget_reg <= BUDGET_W'(SCAN_BUDGET)))
        else $error("scan budget counter overran");

    a_mul_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> (state_reg == ST_EDGE || state_reg == ST_MUL_A))
        else $error("multiplier started outside crossing test");

    a_found_scan_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && res_found_reg) |-> scan_active_reg)
        else $error("covered cell reported with no active scan");

endmodule

[hw/rtl/qtcs_cfg_regs.sv]
// Configuration register file: four packed vertices and the tile size.
// Depends on qtcs_pkg.
module qtcs_cfg_regs
    import qtcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VERT_REG_W-1:0] cfg_data,
    output vert_bank_t            vert_bank,
    output logic [SIZE_W-1:0]     tile_size
);

    vert_bank_t          vert_reg, vert_next;
    logic [SIZE_W-1:0]   tile_reg, tile_next;

    assign cfg_ready = 1'b1;
    assign vert_bank = vert_reg;
    assign tile_size = tile_reg;

    always_comb begin
        vert_next = vert_reg;
        tile_next = tile_reg;
        if (cfg_valid) begin
            unique case (cfg_index) inside
                REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C, REG_VERTEX_D: begin
                    vert_next[cfg_index[VIDX_W-1:0]] = cfg_data;
                end
                REG_TILE_SIZE: begin
                    tile_next = cfg_data[SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vert_reg <= '0;
            tile_reg <= TILE_RESET;
        end else begin
            vert_reg <= vert_next;
            tile_reg <= tile_next;
        end
    end

endmodule

[hw/rtl/qtcs_mul_unit.sv]
// Shared iterative multiplier: one 16-bit digit of the second operand per cycle.
// Depends on qtcs_pkg.
module qtcs_mul_unit
    import qtcs_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [COORD_WIDTH-1:0]   op_a,
    input  logic [COORD_WIDTH-1:0]   op_b,
    output logic                     done,
    output logic [2*COORD_WIDTH-1:0] prod
);

    localparam int CW   = COORD_WIDTH;
    localparam int NDIG = (CW + DIG_W - 1) / DIG_W;
    localparam int BPAD = NDIG * DIG_W;
    localparam int PW   = 2 * CW;
    localparam int PPW  = CW + DIG_W;
    localparam int KW   = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [CW-1:0]   a_reg, a_next;
    logic [BPAD-1:0] b_reg, b_next;
    logic [PW-1:0]   acc_reg, acc_next;

    logic [BPAD-1:0]  b_shift;
    logic [DIG_W-1:0] dig;
    logic [PPW-1:0]   pp;
    logic             last_dig;

    assign b_shift  = b_reg >> (DIG_W * int'(k_reg));
    assign dig      = b_shift[DIG_W-1:0];
    assign pp       = PPW'(a_reg) * PPW'(dig);
    assign last_dig = (k_reg == KW'(NDIG - 1));
    assign done     = done_reg;
    assign prod     = acc_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            k_next    = '0;
            a_next    = op_a;
            b_next    = BPAD'(op_b);
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + (PW'(pp) << (DIG_W * int'(k_reg)));
            k_next   = k_reg + KW'(1);
            if (last_dig) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    a_no_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");

    a_busy_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && last_dig && !start) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after last digit");

endmodule
